// ===== design/file_uri_percent_decoder_unit_assert.svh =====
// Assertion macros shared by the file URI decoder's checker.
// Each macro expands to one labeled concurrent assertion, clocked and reset-qualified.
`ifndef FILE_URI_PERCENT_DECODER_UNIT_ASSERT_SVH
`define FILE_URI_PERCENT_DECODER_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FUPD_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define FUPD_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/fupd_pkg.sv =====
// Package for the file URI percent decoder: constants, escape phase type,
// the result batch struct and the character helper functions. No dependencies.
package fupd_pkg;

    localparam int PREFIX_LEN = 7;
    localparam int MAX_RES    = 7;
    localparam int CNT_W      = $clog2(MAX_RES + 1);
    localparam int TAIL_MAX   = 3;
    localparam int TAIL_W     = $clog2(TAIL_MAX);

    localparam logic [7:0] PCT_CHAR = 8'h25;
    localparam logic [7:0] CHAR_0   = 8'h30;
    localparam logic [7:0] CHAR_9   = 8'h39;
    localparam logic [7:0] CHAR_LA  = 8'h61;
    localparam logic [7:0] CHAR_LF  = 8'h66;
    localparam logic [7:0] CHAR_UA  = 8'h41;
    localparam logic [7:0] CHAR_UF  = 8'h46;

    // Escape decoder phase.
    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_PCT   = 2'd1,
        PH_DIGIT = 2'd2
    } phase_t;

    // All results caused by one input item, first result in the lowest byte.
    typedef struct packed {
        logic [MAX_RES-1:0][7:0] data;
        logic [CNT_W-1:0]        count;
        logic                    fin;
        logic                    bare;
    } batch_t;

    // Characters of the "file://" prefix.
    function automatic logic [7:0] prefix_char(input logic [2:0] idx);
        logic [7:0] c;
        unique case (idx) inside
            3'd0:       c = 8'h66;
            3'd1:       c = 8'h69;
            3'd2:       c = 8'h6c;
            3'd3:       c = 8'h65;
            3'd4:       c = 8'h3a;
            3'd5, 3'd6: c = 8'h2f;
            default:    c = 8'h00;
        endcase
        return c;
    endfunction

    // Hex digit decode: bit 4 is the valid flag, bits 3:0 the digit value.
    function automatic logic [4:0] hex_decode(input logic [7:0] c);
        logic [7:0] d;
        logic       ok;
        d  = 8'h00;
        ok = 1'b0;
        if (c >= CHAR_0 && c <= CHAR_9) begin
            d  = c - CHAR_0;
            ok = 1'b1;
        end else if (c >= CHAR_LA && c <= CHAR_LF) begin
            d  = c - CHAR_LA + 8'd10;
            ok = 1'b1;
        end else if (c >= CHAR_UA && c <= CHAR_UF) begin
            d  = c - CHAR_UA + 8'd10;
            ok = 1'b1;
        end
        return {ok, d[3:0]};
    endfunction

endpackage

// ===== design/fupd_core.sv =====
// Decoder core: prefix match and escape state registers plus the logic that
// turns one input byte into a batch of up to seven results. Uses fupd_pkg.
module fupd_core (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            advance,
    input  logic [7:0]      in_byte,
    input  logic            in_final,
    output fupd_pkg::batch_t batch
);
    import fupd_pkg::*;

    logic [2:0]  pos_reg, pos_next;
    logic        over_reg, over_next;
    phase_t      phase_reg, phase_next;
    logic [7:0]  held_reg, held_next;

    logic        match;
    logic        is_pct;
    logic [4:0]  hex_b;
    logic [4:0]  hex_h;
    phase_t      ph_in;
    phase_t      ph_after;
    logic [7:0]  held_after;
    logic [TAIL_MAX-1:0][7:0] tail;
    logic [TAIL_W-1:0]        tcnt;
    logic [2:0]  k;
    logic [3:0]  total;
    logic [2:0]  idx;

    assign is_pct = (in_byte == PCT_CHAR);
    assign hex_b  = hex_decode(in_byte);
    assign hex_h  = hex_decode(held_reg);
    assign match  = !over_reg && (pos_reg < 3'(PREFIX_LEN)) && (in_byte == prefix_char(pos_reg));
    assign ph_in  = over_reg ? phase_reg : PH_IDLE;

    // Escape decode of the current byte, including the flush at string end.
    always_comb begin
        ph_after   = PH_IDLE;
        held_after = 8'h00;
        tail       = '0;
        tcnt       = '0;
        unique case (ph_in)
            PH_PCT: begin
                if (hex_b[4]) begin
                    ph_after   = PH_DIGIT;
                    held_after = in_byte;
                end else begin
                    tail[tcnt] = PCT_CHAR;
                    tcnt       = tcnt + 1'b1;
                    if (is_pct) begin
                        ph_after = PH_PCT;
                    end else begin
                        tail[tcnt] = in_byte;
                        tcnt       = tcnt + 1'b1;
                    end
                end
            end
            PH_DIGIT: begin
                if (hex_b[4]) begin
                    tail[tcnt] = {hex_h[3:0], hex_b[3:0]};
                    tcnt       = tcnt + 1'b1;
                end else begin
                    tail[tcnt] = PCT_CHAR;
                    tcnt       = tcnt + 1'b1;
                    tail[tcnt] = held_reg;
                    tcnt       = tcnt + 1'b1;
                    if (is_pct) begin
                        ph_after = PH_PCT;
                    end else begin
                        tail[tcnt] = in_byte;
                        tcnt       = tcnt + 1'b1;
                    end
                end
            end
            default: begin
                if (is_pct) begin
                    ph_after = PH_PCT;
                end else begin
                    tail[tcnt] = in_byte;
                    tcnt       = tcnt + 1'b1;
                end
            end
        endcase
        // A pending escape is emitted as is when the string ends.
        if (in_final) begin
            if (ph_after == PH_PCT) begin
                tail[tcnt] = PCT_CHAR;
                tcnt       = tcnt + 1'b1;
            end else if (ph_after == PH_DIGIT) begin
                tail[tcnt] = PCT_CHAR;
                tcnt       = tcnt + 1'b1;
                tail[tcnt] = held_after;
                tcnt       = tcnt + 1'b1;
            end
        end
    end

    // Next state of the prefix matcher and escape decoder.
    always_comb begin
        pos_next   = pos_reg;
        over_next  = over_reg;
        phase_next = phase_reg;
        held_next  = held_reg;
        if (match) begin
            pos_next = pos_reg + 3'd1;
            if (pos_reg == 3'(PREFIX_LEN - 1)) begin
                over_next = 1'b1;
            end
        end else begin
            over_next  = 1'b1;
            phase_next = ph_after;
            held_next  = held_after;
        end
        if (in_final) begin
            pos_next   = 3'd0;
            over_next  = 1'b0;
            phase_next = PH_IDLE;
            held_next  = 8'h00;
        end
    end

    // Result batch: released prefix bytes followed by the decoded tail.
    always_comb begin
        k     = 3'd0;
        idx   = 3'd0;
        batch = '0;
        if (match) begin
            // A string that ends inside a partial prefix releases it whole.
            if (in_final && pos_reg != 3'(PREFIX_LEN - 1)) begin
                k = pos_reg + 3'd1;
            end
            total = {1'b0, k};
        end else begin
            k     = over_reg ? 3'd0 : pos_reg;
            total = {1'b0, k} + {{(4 - TAIL_W){1'b0}}, tcnt};
        end
        for (int i = 0; i < MAX_RES; i++) begin
            idx = 3'(i) - k;
            if (3'(i) < k) begin
                batch.data[i] = prefix_char(3'(i));
            end else if (!match && idx < 3'(TAIL_MAX)) begin
                batch.data[i] = tail[idx[TAIL_W-1:0]];
            end else begin
                batch.data[i] = 8'h00;
            end
        end
        batch.count = (total > 4'(MAX_RES)) ? CNT_W'(MAX_RES) : total[CNT_W-1:0];
        batch.fin   = in_final;
        batch.bare  = 1'b0;
        // Every string end yields a result, a bare marker if nothing else.
        if (in_final && total == 4'd0) begin
            batch.count = CNT_W'(1);
            batch.bare  = 1'b1;
        end
    end

    // State registers, updated as an item leaves the input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg   <= 3'd0;
            over_reg  <= 1'b0;
            phase_reg <= PH_IDLE;
            held_reg  <= 8'h00;
        end else if (advance) begin
            pos_reg   <= pos_next;
            over_reg  <= over_next;
            phase_reg <= phase_next;
            held_reg  <= held_next;
        end
    end

endmodule

// ===== design/fupd_emit.sv =====
// Result emitter: holds one batch of results and presents them on the
// master stream one per cycle while the receiver is ready. Uses fupd_pkg for the batch struct.
module fupd_emit (
    input  logic             aclk,
    input  logic             aresetn,
    input  fupd_pkg::batch_t batch,
    input  logic             load,
    output logic             list_free,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [7:0]       m_tdata,   // out_byte
    output logic             m_tlast,   // string_end
    output logic [1:0]       m_tuser    // has_byte, run_last
);
    import fupd_pkg::*;

    logic [MAX_RES-1:0][7:0] data_reg, data_next;
    logic [CNT_W-1:0]        count_reg, count_next;
    logic                    fin_reg, fin_next;
    logic                    bare_reg, bare_next;
    logic                    take;
    logic                    at_last;

    assign at_last   = (count_reg == CNT_W'(1));
    assign take      = m_tvalid && m_tready;
    assign list_free = (count_reg == '0) || (at_last && m_tready);

    // Output view of the head of the batch.
    assign m_tvalid = (count_reg != '0);
    assign m_tdata  = data_reg[0];
    assign m_tlast  = fin_reg && at_last;
    assign m_tuser  = {at_last, !bare_reg};

    // Load a new batch or shift the taken result out.
    always_comb begin
        data_next  = data_reg;
        count_next = count_reg;
        fin_next   = fin_reg;
        bare_next  = bare_reg;
        if (load) begin
            data_next  = batch.data;
            count_next = batch.count;
            fin_next   = batch.fin;
            bare_next  = batch.bare;
        end else if (take) begin
            data_next  = data_reg >> 8;
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
        fin_reg  <= fin_next;
        bare_reg <= bare_next;
    end

endmodule

// ===== design/file_uri_percent_decoder_unit.sv =====
// File URI percent decoder, top level: input register, decoder core and
// result emitter. Depends on fupd_pkg, fupd_core and fupd_emit.
//
// Usage: the slave stream carries one path byte per item in s_tdata with
// s_tlast on the final byte of a string. A leading "file://" is stripped and
// percent escapes are decoded. The master stream carries result items: the
// byte in m_tdata, m_tuser[0] set when a byte is present (clear on a bare end
// marker), m_tuser[1] set on the last result caused by an input byte, and
// m_tlast on the final result of the string.
// Path: an accepted byte waits in the input register, is decoded by the core,
// and its batch is loaded into the emitter, from which its results are taken.
// Throughput: one byte per cycle while each byte yields at most one result and
// the receiver is ready; a byte that yields more results (up to 7) holds the
// emitter until all are taken, as the emitter delivers one result per ready cycle.
// Reset: aresetn low clears the input register, the emitter and all prefix
// and escape state. When the receiver stalls, the current result holds and
// the input register fills; s_tready then drops until results drain.
module file_uri_percent_decoder_unit (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // in_byte
    input  logic       s_tlast,   // is_final
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // out_byte
    output logic       m_tlast,   // string_end
    output logic [1:0] m_tuser    // has_byte, run_last
);
    import fupd_pkg::*;

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_final_reg;
    logic       list_free;
    logic       advance;
    batch_t     batch;

    // An item moves on once the emitter can take its whole batch.
    assign advance  = in_valid_reg && list_free;
    assign s_tready = !in_valid_reg || advance;

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg  <= s_tdata;
            in_final_reg <= s_tlast;
        end
    end

    fupd_core u_core (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .advance  (advance),
        .in_byte  (in_byte_reg),
        .in_final (in_final_reg),
        .batch    (batch)
    );

    fupd_emit u_emit (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .batch     (batch),
        .load      (advance),
        .list_free (list_free),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

endmodule

// ===== design/fupd_checker.sv =====
// Port-level checker for the file URI percent decoder, bound to the top level.
// Uses the assertion macros from file_uri_percent_decoder_unit_assert.svh.
`include "file_uri_percent_decoder_unit_assert.svh"

module fupd_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic [7:0] s_tdata,
    input logic       s_tlast,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tlast,
    input logic [1:0] m_tuser
);

    // A stalled result item holds its payload.
    `FUPD_ASSERT_NEXT(a_stall_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast) && $stable(m_tuser), "result item changed while stalled")

    // The end of a string is always the last result of its input byte.
    `FUPD_ASSERT_SAME(a_end_is_run_last, aclk, aresetn, m_tvalid && m_tlast, m_tuser[1], "string end without run end")

    // A result without a byte is only the bare end marker, carrying zero.
    `FUPD_ASSERT_SAME(a_bare_marker, aclk, aresetn, m_tvalid && !m_tuser[0], m_tlast && m_tdata == 8'h00, "bare result that is not an end marker")

    // More results of the same input byte follow without a gap.
    `FUPD_ASSERT_NEXT(a_run_no_gap, aclk, aresetn, m_tvalid && m_tready && !m_tuser[1], m_tvalid, "gap inside the results of one input byte")

endmodule

bind file_uri_percent_decoder_unit fupd_checker u_fupd_checker (.*);

// ===== tb/tb_file_uri_percent_decoder_unit.sv =====
// Self-checking testbench for the file URI percent decoder: drives path strings,
// predicts results (typed rows give theirs), compares them with the master stream.
// Depends on fupd_pkg and file_uri_percent_decoder_unit.
module tb_file_uri_percent_decoder_unit;

    timeunit 1ns;
    timeprecision 1ps;

    import fupd_pkg::*;

    localparam int          CYCLE_LIMIT  = 200000;
    localparam int          DRAIN_CYCLES = 16;
    localparam int          MAX_REPORTS  = 10;
    localparam logic [55:0] URI_SCHEME   = "file://";

    // One result item as seen on the master side.
    typedef struct packed {
        logic [7:0] data;
        logic       has_byte;
        logic       string_end;
        logic       run_last;
    } uri_result_t;

    // One row of the directed stimulus; typed rows carry their single result.
    typedef struct packed {
        logic [7:0]  data;
        logic        last;
        logic        typed;
        uri_result_t want;
    } stim_row_t;

    logic       aclk;
    logic       aresetn;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;
    logic       s_tlast;
    logic       m_tvalid;
    logic       m_tready;
    logic [7:0] m_tdata;
    logic       m_tlast;
    logic [1:0] m_tuser;

    // Decoder state mirrored by the predictor.
    logic [2:0] scheme_matched;
    logic       scheme_settled;
    phase_t     esc_phase;
    logic [7:0] first_digit;

    logic [7:0]  decoded_bytes[$];
    uri_result_t item_results[$];
    uri_result_t pending_results[$];
    stim_row_t   directed_rows[$];
    logic [7:0]  path_text[$];

    int tx_gap_pct;
    int rx_stall_pct;
    int items_sent;
    int fault_count;
    int cycle_count;

    file_uri_percent_decoder_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    // Free-running clock.
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Character idx of the "file://" scheme.
    function automatic logic [7:0] scheme_char(input int idx);
        return URI_SCHEME[8*(PREFIX_LEN-1-idx) +: 8];
    endfunction

    // Returns 1 for a hex digit of either case and its value in v.
    function automatic bit is_hex_digit(input logic [7:0] c, output logic [3:0] v);
        v = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            v = 4'(c - 8'h30);
            return 1'b1;
        end
        if (c >= 8'h61 && c <= 8'h66) begin
            v = 4'(c - 8'h61 + 8'd10);
            return 1'b1;
        end
        if (c >= 8'h41 && c <= 8'h46) begin
            v = 4'(c - 8'h41 + 8'd10);
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic void reset_decoder_state();
        scheme_matched = 3'd0;
        scheme_settled = 1'b0;
        esc_phase      = PH_IDLE;
        first_digit    = 8'h00;
    endfunction

    // Appends one byte to the decoded output of the current item.
    function automatic void emit_byte(input logic [7:0] b);
        decoded_bytes.insert(decoded_bytes.size(), b);
    endfunction

    // Outside an escape a '%' opens one, anything else passes through.
    function automatic void scan_plain(input logic [7:0] b);
        if (b == PCT_CHAR) begin
            esc_phase = PH_PCT;
        end else begin
            emit_byte(b);
        end
    endfunction

    // Escape decoding of one byte; a broken escape gives back '%' and rescans.
    function automatic void decode_escape_byte(input logic [7:0] b);
        logic [3:0] hi;
        logic [3:0] lo;
        case (esc_phase)
            PH_PCT: begin
                if (is_hex_digit(b, lo)) begin
                    first_digit = b;
                    esc_phase   = PH_DIGIT;
                end else begin
                    emit_byte(PCT_CHAR);
                    esc_phase = PH_IDLE;
                    scan_plain(b);
                end
            end
            PH_DIGIT: begin
                void'(is_hex_digit(first_digit, hi));
                esc_phase = PH_IDLE;
                if (is_hex_digit(b, lo)) begin
                    emit_byte({hi, lo});
                end else begin
                    emit_byte(PCT_CHAR);
                    emit_byte(first_digit);
                    scan_plain(b);
                end
                first_digit = 8'h00;
            end
            default: begin
                esc_phase = PH_IDLE;
                scan_plain(b);
            end
        endcase
    endfunction

    // Scheme bytes held back so far go through the escape decoder in order.
    function automatic void release_scheme_bytes();
        for (int i = 0; i < int'(scheme_matched); i++)
            decode_escape_byte(scheme_char(i));
    endfunction

    // Works out every result item caused by one accepted path byte.
    function automatic void decode_path_byte(input logic [7:0] b, input logic fin);
        int n;
        decoded_bytes.delete();
        item_results.delete();
        if (!scheme_settled) begin
            if (int'(scheme_matched) < PREFIX_LEN && b == scheme_char(int'(scheme_matched)))
            begin
                scheme_matched = scheme_matched + 3'd1;
                if (int'(scheme_matched) == PREFIX_LEN)
                    scheme_settled = 1'b1;
            end else begin
                release_scheme_bytes();
                decode_escape_byte(b);
                scheme_settled = 1'b1;
            end
        end else begin
            decode_escape_byte(b);
        end

        // Flush whatever is still held when the string ends.
        if (fin) begin
            if (!scheme_settled)
                release_scheme_bytes();
            if (esc_phase == PH_PCT) begin
                emit_byte(PCT_CHAR);
            end else if (esc_phase == PH_DIGIT) begin
                emit_byte(PCT_CHAR);
                emit_byte(first_digit);
            end
        end

        n = decoded_bytes.size();
        for (int k = 0; k < n; k++)
            item_results.insert(item_results.size(),
                                '{decoded_bytes[k], 1'b1, fin && (k == n - 1), k == n - 1});
        if (fin && n == 0)
            item_results.insert(item_results.size(), '{8'h00, 1'b0, 1'b1, 1'b1});
        if (fin)
            reset_decoder_state();
    endfunction

    // Appends one row to the directed stimulus.
    function automatic void add_row(input stim_row_t row);
        directed_rows.insert(directed_rows.size(), row);
    endfunction

    // Directed rows: every character of s, final flag on the last one if asked.
    function automatic void add_text(input string s, input logic fin);
        for (int i = 0; i < s.len(); i++)
            add_row('{s[i], fin && (i == s.len() - 1), 1'b0, '0});
    endfunction

    function automatic void build_directed_rows();
        // Extreme byte values as one-byte strings.
        add_row('{8'h00, 1'b1, 1'b1, '{8'h00, 1'b1, 1'b1, 1'b1}});
        add_row('{8'hff, 1'b1, 1'b1, '{8'hff, 1'b1, 1'b1, 1'b1}});
        // A complete scheme alone leaves nothing but the bare end marker.
        add_text("file:/", 1'b0);
        add_row('{8'h2f, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, 1'b1}});
        // Scheme broken on its last byte by '%', escape still open at the end.
        add_text("file:/%", 1'b1);
        // String ending inside a partial scheme.
        add_text("fi", 1'b1);
        // Double percent, both hex cases, and a half escape at the end.
        add_text("%%41%aF%4", 1'b1);
    endfunction

    // One hex digit character, either case.
    function automatic logic [7:0] random_hex_char();
        int idx;
        idx = $urandom_range(0, 21);
        if (idx < 10)
            return 8'(8'h30 + idx);
        if (idx < 16)
            return 8'(8'h61 + idx - 10);
        return 8'(8'h41 + idx - 16);
    endfunction

    // Appends one byte to the path being built.
    function automatic void add_path_byte(input logic [7:0] b);
        path_text.insert(path_text.size(), b);
    endfunction

    // Appends one piece of path content, biased toward escapes.
    function automatic void add_random_token();
        int r;
        r = $urandom_range(0, 99);
        if (r < 30) begin
            add_path_byte(PCT_CHAR);
            add_path_byte(random_hex_char());
            add_path_byte(random_hex_char());
        end else if (r < 45) begin
            add_path_byte(PCT_CHAR);
        end else if (r < 65) begin
            add_path_byte(random_hex_char());
        end else if (r < 80) begin
            add_path_byte(8'($urandom_range(32, 126)));
        end else begin
            add_path_byte(8'($urandom_range(0, 255)));
        end
    endfunction

    // Presents one item, waits for its handshake and records its results.
    task automatic send_item(input logic [7:0] b, input logic fin, input logic typed,
                             input uri_result_t want);
        while ($urandom_range(0, 99) < tx_gap_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= fin;
        do
            @(posedge aclk);
        while (!s_tready);
        items_sent++;
        decode_path_byte(b, fin);
        if (typed) begin
            pending_results.insert(pending_results.size(), want);
        end else begin
            foreach (item_results[k])
                pending_results.insert(pending_results.size(), item_results[k]);
        end
        @(negedge aclk);
    endtask

    // Builds one random path string and sends it.
    task automatic send_random_path();
        int kind;
        int n;
        path_text.delete();
        kind = $urandom_range(0, 9);
        if (kind <= 3) begin
            for (int k = 0; k < PREFIX_LEN; k++)
                add_path_byte(scheme_char(k));
        end else if (kind <= 5 || kind == 7) begin
            n = $urandom_range(1, PREFIX_LEN - 1);
            for (int k = 0; k < n; k++)
                add_path_byte(scheme_char(k));
        end
        if (kind == 6) begin
            n = $urandom_range(1, 10);
            repeat (n) add_path_byte(8'($urandom_range(0, 255)));
        end else if (kind != 7) begin
            n = $urandom_range(0, 8);
            repeat (n) add_random_token();
        end
        if (path_text.size() == 0)
            add_path_byte(8'($urandom_range(0, 255)));
        foreach (path_text[k])
            send_item(path_text[k], k == path_text.size() - 1, 1'b0, '0);
    endtask

    // Receiver back-pressure, redrawn every cycle.
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            m_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
        end
    end

    // Result checker: each accepted result against the oldest expectation.
    always @(posedge aclk) begin
        uri_result_t got;
        uri_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = '{m_tdata, m_tuser[0], m_tlast, m_tuser[1]};
            if (pending_results.size() == 0) begin
                fault_count++;
                if (fault_count <= MAX_REPORTS)
                    $display("unexpected result: byte=%h has_byte=%b end=%b run_last=%b",
                             got.data, got.has_byte, got.string_end, got.run_last);
            end else begin
                want = pending_results.pop_front();
                if (got.data !== want.data || got.has_byte !== want.has_byte ||
                    got.string_end !== want.string_end || got.run_last !== want.run_last)
                begin
                    fault_count++;
                    if (fault_count <= MAX_REPORTS) begin
                        $display("result mismatch (expected/actual): byte %h/%h has_byte %b/%b",
                                 want.data, got.data, want.has_byte, got.has_byte);
                        $display("    end %b/%b run_last %b/%b",
                                 want.string_end, got.string_end,
                                 want.run_last, got.run_last);
                    end
                end
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[file_uri_percent_decoder_unit] ERROR");
            $finish;
        end
    end

    // Reset, directed rows, then three random phases with different idling.
    initial begin
        aresetn      = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = 8'h00;
        s_tlast      = 1'b0;
        tx_gap_pct   = 6;
        rx_stall_pct = 60;
        items_sent   = 0;
        fault_count  = 0;
        cycle_count  = 0;
        reset_decoder_state();
        build_directed_rows();

        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (directed_rows[i])
            send_item(directed_rows[i].data, directed_rows[i].last,
                      directed_rows[i].typed, directed_rows[i].want);

        while (items_sent < 60)
            send_random_path();
        tx_gap_pct   = 60;
        rx_stall_pct = 6;
        while (items_sent < 120)
            send_random_path();
        tx_gap_pct   = 0;
        rx_stall_pct = 0;
        while (items_sent < 180)
            send_random_path();
        s_tvalid <= 1'b0;

        // Let the last results drain, then watch for strays.
        while (pending_results.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (fault_count == 0 && pending_results.size() == 0) begin
            $display("[file_uri_percent_decoder_unit] OK");
        end else begin
            $display("[file_uri_percent_decoder_unit] ERROR");
        end
        $finish;
    end

endmodule

// ===== file_uri_percent_decoder_unit.f =====
+incdir+design
design/fupd_pkg.sv
design/fupd_core.sv
design/fupd_emit.sv
design/file_uri_percent_decoder_unit.sv
design/fupd_checker.sv
tb/tb_file_uri_percent_decoder_unit.sv
